### rtl/acld_pkg.sv
// Shared types and constants for the ASCII command line decoder.
package acld_pkg;

    localparam int CMD_COUNT = 5;

    typedef enum logic [2:0] {
        ACT_LEDR  = 3'd0,
        ACT_LEDG  = 3'd1,
        ACT_LEDB  = 3'd2,
        ACT_DIR   = 3'd3,
        ACT_MOTOR = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        NUM_BEFORE = 2'd0,
        NUM_IN     = 2'd1,
        NUM_DONE   = 2'd2
    } num_phase_t;

    typedef struct packed {
        num_phase_t  phase;
        logic        negative;
        logic [15:0] acc;
    } num_state_t;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_VT    = 8'h0B;
    localparam logic [7:0] CHAR_FF    = 8'h0C;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // prefix text, padded with NUL to eight columns
    localparam logic [7:0] CMD_TEXT [CMD_COUNT][8] = '{
        '{"L", "E", "D", "R", "=", 8'h00, 8'h00, 8'h00},
        '{"L", "E", "D", "G", "=", 8'h00, 8'h00, 8'h00},
        '{"L", "E", "D", "B", "=", 8'h00, 8'h00, 8'h00},
        '{"D", "I", "R", "=", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"M", "O", "T", "O", "R", "=", 8'h00, 8'h00}
    };

    localparam logic [2:0] CMD_LEN [CMD_COUNT] = '{3'd5, 3'd5, 3'd5, 3'd4, 3'd6};

endpackage

### rtl/ascii_command_line_decoder.sv
// Top level: streaming decoder of LED, DIR and MOTOR command lines.
//
//  channel | dir | handshake            | payload
//  rx      | in  | rx_valid / rx_ready  | rx_byte[7:0]
//  cmd     | out | cmd_valid / cmd_ready| action[2:0], value[15:0], level
//
// One byte per cycle unless a stalled result holds the input register; a line-end
// byte goes from the input register to the result register, which raises
// cmd_valid.
// Line state updates in the same cycle as the byte leaves the input register.
// Reset clears line state and both valid flags; no clearing pass is needed.
// A stalled result holds the input register; rx_ready is low only during such a stall.
module ascii_command_line_decoder
#(
    parameter int LINE_CAPACITY = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rx_valid,
    output logic        rx_ready,
    input  logic [7:0]  rx_byte,
    output logic        cmd_valid,
    input  logic        cmd_ready,
    output logic [2:0]  action,
    output logic [15:0] value,
    output logic        level
);

    localparam int POS_W = $clog2(LINE_CAPACITY);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(LINE_CAPACITY - 1);

    logic                 in_valid_reg;
    logic [7:0]           in_byte_reg;
    logic                 advance;

    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [4:0]           cand_reg, cand_next;
    logic                 ended_reg, ended_next;
    acld_pkg::num_state_t num_reg, num_next, num_stepped;

    logic                 out_valid_reg, out_valid_next;
    logic [2:0]           action_reg, action_next;
    logic [15:0]          value_reg, value_next;
    logic                 level_reg, level_next;

    logic                 is_eol;
    logic                 num_en;
    logic [4:0]           cand_kept;
    logic                 hit;
    logic [2:0]           hit_idx;
    logic [15:0]          signed_val;

    assign advance  = in_valid_reg && (!out_valid_reg || cmd_ready);
    assign rx_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (rx_ready)
            in_valid_reg <= rx_valid;
    end

    always_ff @(posedge clk)
    begin
        if (rx_ready && rx_valid)
            in_byte_reg <= rx_byte;
    end

    acld_number u_number
    (
        .rx_char (in_byte_reg),
        .cur     (num_reg),
        .nxt     (num_stepped)
    );

    assign is_eol = (in_byte_reg == acld_pkg::CHAR_LF) || (in_byte_reg == acld_pkg::CHAR_CR);

    always_comb
    begin
        cand_kept = cand_reg;
        num_en    = 1'b0;
        for (int k = 0; k < acld_pkg::CMD_COUNT; k++)
        begin
            if (cand_reg[k])
            begin
                if (pos_reg < POS_W'(acld_pkg::CMD_LEN[k]))
                begin
                    if (in_byte_reg != acld_pkg::CMD_TEXT[k][pos_reg[2:0]])
                        cand_kept[k] = 1'b0;
                end
                else
                begin
                    num_en = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        hit     = 1'b0;
        hit_idx = 3'd0;
        for (int k = acld_pkg::CMD_COUNT - 1; k >= 0; k--)
        begin
            if (cand_reg[k] && (pos_reg >= POS_W'(acld_pkg::CMD_LEN[k])))
            begin
                hit     = 1'b1;
                hit_idx = 3'(k);
            end
        end
    end

    assign signed_val = num_reg.negative ? (16'd0 - num_reg.acc) : num_reg.acc;

    always_comb
    begin
        pos_next       = pos_reg;
        cand_next      = cand_reg;
        ended_next     = ended_reg;
        num_next       = num_reg;
        out_valid_next = out_valid_reg && !cmd_ready;
        action_next    = action_reg;
        value_next     = value_reg;
        level_next     = level_reg;
        if (advance)
        begin
            if (is_eol)
            begin
                pos_next       = '0;
                cand_next      = '1;
                ended_next     = 1'b0;
                num_next       = '{phase: acld_pkg::NUM_BEFORE, negative: 1'b0, acc: 16'd0};
                if (hit)
                begin
                    out_valid_next = 1'b1;
                    action_next    = hit_idx;
                    if (hit_idx == acld_pkg::ACT_MOTOR)
                    begin
                        value_next = signed_val;
                        level_next = 1'b0;
                    end
                    else
                    begin
                        value_next = {8'd0, signed_val[7:0]};
                        level_next = |signed_val[7:0];
                    end
                end
            end
            else if (!ended_reg && (pos_reg < POS_LAST))
            begin
                if (in_byte_reg == acld_pkg::CHAR_NUL)
                begin
                    ended_next = 1'b1;
                end
                else
                begin
                    cand_next = cand_kept;
                    pos_next  = pos_reg + POS_W'(1);
                    if (num_en)
                        num_next = num_stepped;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            cand_reg      <= '1;
            ended_reg     <= 1'b0;
            num_reg       <= '{phase: acld_pkg::NUM_BEFORE, negative: 1'b0, acc: 16'd0};
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            cand_reg      <= cand_next;
            ended_reg     <= ended_next;
            num_reg       <= num_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg <= action_next;
        value_reg  <= value_next;
        level_reg  <= level_next;
    end

    assign cmd_valid = out_valid_reg;
    assign action    = action_reg;
    assign value     = value_reg;
    assign level     = level_reg;

endmodule

### rtl/acld_number.sv
// Next-state logic for the atoi-style number scan of one character.
module acld_number
(
    input  logic [7:0]           rx_char,
    input  acld_pkg::num_state_t cur,
    output acld_pkg::num_state_t nxt
);

    logic        digit;
    logic        blank;
    logic [15:0] digit_val;
    logic [15:0] acc_x10;

    assign digit = (rx_char >= acld_pkg::CHAR_ZERO) && (rx_char <= acld_pkg::CHAR_NINE);
    assign blank = (rx_char == acld_pkg::CHAR_SPACE) || (rx_char == acld_pkg::CHAR_TAB) ||
                   (rx_char == acld_pkg::CHAR_VT) || (rx_char == acld_pkg::CHAR_FF);
    assign digit_val = {12'd0, rx_char[3:0]};
    assign acc_x10   = {cur.acc[12:0], 3'b000} + {cur.acc[14:0], 1'b0};

    always_comb
    begin
        nxt = cur;
        unique case (cur.phase)
            acld_pkg::NUM_BEFORE:
            begin
                if (blank)
                begin
                    nxt = cur;
                end
                else if ((rx_char == acld_pkg::CHAR_PLUS) || (rx_char == acld_pkg::CHAR_MINUS))
                begin
                    nxt.negative = (rx_char == acld_pkg::CHAR_MINUS);
                    nxt.phase    = acld_pkg::NUM_IN;
                end
                else if (digit)
                begin
                    nxt.acc   = digit_val;
                    nxt.phase = acld_pkg::NUM_IN;
                end
                else
                begin
                    nxt.phase = acld_pkg::NUM_DONE;
                end
            end
            acld_pkg::NUM_IN:
            begin
                if (digit)
                    nxt.acc = acc_x10 + digit_val;
                else
                    nxt.phase = acld_pkg::NUM_DONE;
            end
            acld_pkg::NUM_DONE:
            begin
                nxt = cur;
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

endmodule

### rtl/acld_checker.sv
// Port-level checks for the command line decoder, bound to the top level.
module acld_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        rx_valid,
    input logic        rx_ready,
    input logic [7:0]  rx_byte,
    input logic        cmd_valid,
    input logic        cmd_ready,
    input logic [2:0]  action,
    input logic [15:0] value,
    input logic        level
);

    logic eol_beat;
    assign eol_beat = rx_valid && rx_ready &&
                      ((rx_byte == acld_pkg::CHAR_LF) || (rx_byte == acld_pkg::CHAR_CR));

    a_cmd_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_ready |=> cmd_valid && $stable(action) && $stable(value))
        else $error("stalled command beat changed");

    a_action_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid |-> action <= acld_pkg::ACT_MOTOR)
        else $error("action code out of range");

    a_led_level: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && (action != acld_pkg::ACT_MOTOR) |->
            (value[15:8] == 8'd0) && (level == (value[7:0] != 8'd0)))
        else $error("led/dir value or level inconsistent");

    a_motor_level: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && (action == acld_pkg::ACT_MOTOR) |-> !level)
        else $error("motor command with level set");

    a_rise_after_eol: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(cmd_valid) |-> $past(eol_beat, 2))
        else $error("command beat without a preceding line end");

endmodule

bind ascii_command_line_decoder acld_checker u_acld_checker (.*);

### verif/tb.sv
// Testbench for ascii_command_line_decoder: byte stream in, predicted commands checked out.
`timescale 1ns / 100ps

module tb;

    localparam int LINE_CAP = 64;

    typedef struct packed {
        acld_pkg::action_t act;
        logic [15:0]       val;
        logic              lvl;
    } command_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        rx_valid = 1'b0;
    logic        rx_ready;
    logic [7:0]  rx_byte = 8'h00;
    logic        cmd_valid;
    logic        cmd_ready = 1'b0;
    logic [2:0]  action;
    logic [15:0] value;
    logic        level;

    // decoder shadow state
    int                   line_pos;
    logic [4:0]           prefix_live;
    acld_pkg::num_phase_t num_phase;
    logic                 num_neg;
    logic [15:0]          num_acc;
    logic                 text_done;

    command_t    cmd_expected[$];
    int          error_count = 0;
    int          bytes_sent = 0;
    bit          gaps_on = 1'b1;
    int          hold_cycles = 0;
    int          stall_left = 0;

    ascii_command_line_decoder #(.LINE_CAPACITY(LINE_CAP)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_valid  (rx_valid),
        .rx_ready  (rx_ready),
        .rx_byte   (rx_byte),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .action    (action),
        .value     (value),
        .level     (level)
    );

    always #5 clk = ~clk;

    function automatic string prefix_of(int k);
        case (k)
            0:       return "LEDR=";
            1:       return "LEDG=";
            2:       return "LEDB=";
            3:       return "DIR=";
            default: return "MOTOR=";
        endcase
    endfunction

    function automatic void clear_line();
        line_pos    = 0;
        prefix_live = 5'b11111;
        num_phase   = acld_pkg::NUM_BEFORE;
        num_neg     = 1'b0;
        num_acc     = 16'd0;
        text_done   = 1'b0;
    endfunction

    function automatic void predict_byte(logic [7:0] b);
        int       k;
        int       hit;
        int       start;
        string    pfx;
        logic     digit;
        logic     blank;
        logic [15:0] v;
        command_t c;
        if (b != acld_pkg::CHAR_LF && b != acld_pkg::CHAR_CR)
        begin
            if (!text_done && line_pos < LINE_CAP - 1)
            begin
                if (b == acld_pkg::CHAR_NUL)
                begin
                    text_done = 1'b1;
                end
                else
                begin
                    start = 0;
                    for (k = 0; k < 5; k++)
                    begin
                        pfx = prefix_of(k);
                        if (prefix_live[k])
                        begin
                            if (line_pos < pfx.len())
                            begin
                                if (b != pfx[line_pos])
                                    prefix_live[k] = 1'b0;
                            end
                            else if (start == 0)
                            begin
                                start = pfx.len();
                            end
                        end
                    end
                    if (start != 0 && line_pos >= start)
                    begin
                        digit = (b >= acld_pkg::CHAR_ZERO && b <= acld_pkg::CHAR_NINE);
                        blank = (b == acld_pkg::CHAR_SPACE || b == acld_pkg::CHAR_TAB
                                 || b == acld_pkg::CHAR_VT || b == acld_pkg::CHAR_FF);
                        case (num_phase)
                            acld_pkg::NUM_BEFORE:
                            begin
                                if (!blank)
                                begin
                                    if (b == acld_pkg::CHAR_PLUS || b == acld_pkg::CHAR_MINUS)
                                    begin
                                        num_neg   = (b == acld_pkg::CHAR_MINUS);
                                        num_phase = acld_pkg::NUM_IN;
                                    end
                                    else if (digit)
                                    begin
                                        num_acc   = {8'h00, b - acld_pkg::CHAR_ZERO};
                                        num_phase = acld_pkg::NUM_IN;
                                    end
                                    else
                                    begin
                                        num_phase = acld_pkg::NUM_DONE;
                                    end
                                end
                            end
                            acld_pkg::NUM_IN:
                            begin
                                if (digit)
                                    num_acc = num_acc * 16'd10
                                              + {8'h00, b - acld_pkg::CHAR_ZERO};
                                else
                                    num_phase = acld_pkg::NUM_DONE;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                    line_pos++;
                end
            end
        end
        else
        begin
            hit = -1;
            for (k = 0; k < 5; k++)
            begin
                pfx = prefix_of(k);
                if (hit < 0 && prefix_live[k] && line_pos >= pfx.len())
                    hit = k;
            end
            v = num_neg ? (16'd0 - num_acc) : num_acc;
            clear_line();
            if (hit >= 0)
            begin
                c.act = acld_pkg::action_t'(hit);
                if (c.act == acld_pkg::ACT_MOTOR)
                begin
                    c.val = v;
                    c.lvl = 1'b0;
                end
                else
                begin
                    c.val = {8'h00, v[7:0]};
                    c.lvl = (v[7:0] != 8'h00);
                end
                cmd_expected.push_back(c);
            end
        end
    endfunction

    task automatic send_byte(input logic [7:0] b);
        if (gaps_on && $urandom_range(0, 7) == 0)
        begin
            rx_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (!rx_ready) @(posedge clk);
        predict_byte(b);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 3))
            0:       return acld_pkg::CHAR_SPACE;
            1:       return acld_pkg::CHAR_TAB;
            2:       return acld_pkg::CHAR_VT;
            default: return acld_pkg::CHAR_FF;
        endcase
    endfunction

    task automatic send_random_line();
        logic [7:0] line_q[$];
        int         kind;
        int         n;
        int         i;
        string      pfx;
        kind = $urandom_range(0, 19);
        if (kind < 15)
        begin
            pfx = prefix_of($urandom_range(0, 4));
            for (i = 0; i < pfx.len(); i++)
                line_q.push_back(pfx[i]);
            if ($urandom_range(0, 9) == 0)
                line_q[$urandom_range(0, line_q.size() - 1)] = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 3) == 0)
            begin
                n = $urandom_range(1, 3);
                repeat (n) line_q.push_back(pick_blank());
            end
            case ($urandom_range(0, 3))
                0:       line_q.push_back(acld_pkg::CHAR_PLUS);
                1:       line_q.push_back(acld_pkg::CHAR_MINUS);
                default: ;
            endcase
            n = $urandom_range(0, 7);
            repeat (n) line_q.push_back(acld_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
            if ($urandom_range(0, 4) == 0)
            begin
                n = $urandom_range(1, 3);
                repeat (n) line_q.push_back(8'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 15) == 0)
                line_q.insert($urandom_range(0, line_q.size()), acld_pkg::CHAR_NUL);
        end
        else if (kind < 19)
        begin
            n = $urandom_range(0, 12);
            repeat (n) line_q.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            pfx = prefix_of($urandom_range(0, 4));
            for (i = 0; i < pfx.len(); i++)
                line_q.push_back(pfx[i]);
            n = $urandom_range(55, 75);
            repeat (n) line_q.push_back(acld_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
        end
        line_q.push_back($urandom_range(0, 1) ? acld_pkg::CHAR_CR : acld_pkg::CHAR_LF);
        if ($urandom_range(0, 7) == 0)
            line_q.push_back(acld_pkg::CHAR_LF);
        foreach (line_q[j])
            send_byte(line_q[j]);
    endtask

    task automatic check_command();
        command_t e;
        if (cmd_expected.size() == 0)
        begin
            $display("%0t: unexpected command action=%0d value=%0d level=%0d",
                     $time, action, value, level);
            error_count++;
        end
        else
        begin
            e = cmd_expected.pop_front();
            if (action != e.act)
            begin
                $display("%0t: action expected %0d actual %0d", $time, e.act, action);
                error_count++;
            end
            if (value != e.val)
            begin
                $display("%0t: value expected %0d actual %0d", $time, e.val, value);
                error_count++;
            end
            if (level != e.lvl)
            begin
                $display("%0t: level expected %0d actual %0d", $time, e.lvl, level);
                error_count++;
            end
        end
    endtask

    // command sink: checks each beat, stalls in bursts and on long hold-offs
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && cmd_valid && cmd_ready)
                check_command();
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                cmd_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                cmd_ready <= 1'b0;
            end
            else if (gaps_on && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 18) - 1;
                cmd_ready <= 1'b0;
            end
            else
            begin
                cmd_ready <= 1'b1;
            end
        end
    end

    task automatic test_directed();
        send_text("LEDR=255\n");
        send_text("LEDG=0\r");
        send_text("LEDB=-1\n");
        send_text("DIR=256\n");
        send_text("MOTOR=65535\r");
        send_text("MOTOR=-70000\n");
        send_text("LEDR=");
        send_byte(acld_pkg::CHAR_TAB);
        send_byte(acld_pkg::CHAR_VT);
        send_byte(acld_pkg::CHAR_FF);
        send_text(" +42\n");
        send_text("DIR=-\n");
        send_text("MOTOR=x9\n");
        send_text("\n");
        send_text("LED\r");
        send_text("LEDX=5\n");
        send_text("MOTOR=12");
        send_byte(acld_pkg::CHAR_NUL);
        send_text("34\n");
        send_byte(acld_pkg::CHAR_NUL);
        send_text("LEDR=3\n");
        send_text("LEDG=7");
        send_byte(8'hFF);
        send_byte(8'h80);
        send_text("9\n");
        send_text("DIR=");
        repeat (70) send_byte("7");
        send_text("\r");
        send_text("MOTOR=  -12abc3\r\n");
    endtask

    task automatic test_random_lines();
        while (bytes_sent < 1100)
            send_random_line();
    endtask

    task automatic test_backpressure();
        int target;
        target = bytes_sent + 150;
        hold_cycles = 400;
        while (bytes_sent < target)
            send_random_line();
    endtask

    task automatic test_full_rate();
        int target;
        target = bytes_sent + 250;
        gaps_on = 1'b0;
        while (bytes_sent < target)
            send_random_line();
    endtask

    task automatic finish_run();
        int i;
        rx_valid <= 1'b0;
        i = 0;
        while (cmd_expected.size() != 0 && i < 5000)
        begin
            @(posedge clk);
            i++;
        end
        repeat (20) @(posedge clk);
        if (cmd_expected.size() != 0)
        begin
            $display("%0t: %0d commands never arrived", $time, cmd_expected.size());
            error_count++;
        end
        if (error_count == 0)
            $display("PASS ascii_command_line_decoder");
        else
            $display("FAIL ascii_command_line_decoder");
        $finish;
    endtask

    initial
    begin
        clear_line();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_random_lines();
        test_backpressure();
        test_full_rate();
        finish_run();
    end

    initial
    begin
        #10_000_000;
        $display("FAIL ascii_command_line_decoder");
        $finish;
    end

endmodule
